// File: design/spb_pkg.sv
// Shared types and constants for the simple path edge builder.
`default_nettype none

package spb_pkg;

	// Fixed field widths
	localparam int EDGE_W    = 32;
	localparam int LEN_OUT_W = 9;

	// Fan-in of each node in the registered match-reduction tree
	localparam int FANIN = 8;

	// Request codes
	typedef logic [1:0] req_code_t;
	localparam req_code_t REQ_EXTEND = 2'd0;
	localparam req_code_t REQ_QUERY  = 2'd1;
	localparam req_code_t REQ_CLEAR  = 2'd2;

	// Status codes
	typedef logic [1:0] status_code_t;
	localparam status_code_t ST_OK     = 2'd0;
	localparam status_code_t ST_REJECT = 2'd1;
	localparam status_code_t ST_FULL   = 2'd2;

	// Request item
	typedef struct packed {
		req_code_t           req_type;
		logic [EDGE_W-1:0]   edge_id;
		logic                strict;
	} spb_cmd_t;

	// Result item
	typedef struct packed {
		status_code_t          status;
		logic                  found;
		logic                  is_simple;
		logic                  is_prime;
		logic                  closed_cycle;
		logic [LEN_OUT_W-1:0]  walk_length;
	} spb_rsp_t;

	// Control broadcast to every cell of the sorted chain
	typedef struct packed {
		logic cmp;   // register compare flags against the key
		logic ins;   // shift right of the insert slot and drop the key in
	} spb_cell_ctl_t;

endpackage

`default_nettype wire

// File: design/spb_cell.sv
// One cell of the sorted edge chain: holds one entry and its compare flags.
`default_nettype none

module spb_cell #(
	parameter int IDX = 0,
	parameter int LW  = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spb_pkg::spb_cell_ctl_t    ctl,
	input  logic [spb_pkg::EDGE_W-1:0] key,
	input  logic [LW-1:0]             len,
	input  logic [spb_pkg::EDGE_W-1:0] left_v,
	input  logic                      left_gt,
	output logic [spb_pkg::EDGE_W-1:0] v_q,
	output logic                      gt_q,
	output logic                      eq_q
);
	import spb_pkg::*;

	logic occupied;

	// entry lies inside the current walk length
	assign occupied = len > LW'(IDX);

	// stored entry: shifts in from the left neighbor or takes the key
	always_ff @(posedge clk) begin
		if (ctl.ins && gt_q) begin
			v_q <= left_gt ? left_v : key;
		end
	end

	// compare flags; empty cells count as greater so they take part in the shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			gt_q <= !occupied || (v_q > key);
			eq_q <= occupied && (v_q == key);
		end
	end

endmodule

`default_nettype wire

// File: design/spb_or_tree.sv
// Registered OR-reduction tree over the per-cell match bits.
`default_nettype none

module spb_or_tree #(
	parameter int N = 256
) (
	input  logic         clk,
	input  logic [N-1:0] leaf,
	output logic         root
);
	import spb_pkg::*;

	// node count at a given level (level 0 is the leaves)
	function automatic int f_cnt(input int n, input int lvl);
		int c;
		c = n;
		for (int i = 0; i < lvl; i++) begin
			c = (c + FANIN - 1) / FANIN;
		end
		return c;
	endfunction

	// number of registered levels down to one node
	function automatic int f_levels(input int n);
		int c;
		int l;
		c = n;
		l = 0;
		while (c > 1) begin
			c = (c + FANIN - 1) / FANIN;
			l++;
		end
		return (l < 1) ? 1 : l;
	endfunction

	localparam int LEVELS = f_levels(N);

	logic [N-1:0] lvl_q [1:LEVELS];
	logic [N-1:0] lvl_d [1:LEVELS];

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		logic [N-1:0] src;

		if (l == 1) begin : g_first
			assign src = leaf;
		end else begin : g_next
			assign src = lvl_q[l-1];
		end

		// each node ORs up to FANIN children of the level below
		always_comb begin
			lvl_d[l] = '0;
			for (int j = 0; j < N; j++) begin
				for (int k = 0; k < FANIN; k++) begin
					if (j < f_cnt(N, l) && (j * FANIN + k) < f_cnt(N, l - 1)) begin
						lvl_d[l][j] = lvl_d[l][j] | src[j * FANIN + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			lvl_q[l] <= lvl_d[l];
		end
	end

	assign root = lvl_q[LEVELS][0];

endmodule

`default_nettype wire

// File: design/simple_path_edge_builder_top.sv
// Top level of the simple path edge builder: control, marks and the cell chain.
//
// Request channel cmd (cmd_valid / cmd_stall) carries one item: extend the
// walk with an edge, query whether an edge is in the walk, or clear the walk.
// Result channel rsp (rsp_valid / rsp_stall) returns exactly one item per
// request: status, found, the simple / prime / cycle marks and the length.
// The walk is kept as a sorted chain of MAX_EDGES cells; every cell compares
// its entry with the key in the same cycle, and the match bits are ORed through a
// registered tree of L = ceil(log8(MAX_EDGES)) levels (3 at the default).
// An item passes from acceptance to the result register through a compare
// state, a wait state while the tree levels fill, a decide / insert state and
// a result load; the tree depth sets the length of the wait. One item is in flight at
// a time; cmd_stall is high from acceptance until the result is loaded, so
// the next item may be taken while a result still waits on rsp.
// While rsp_stall is high the result holds; a finished item waits for the
// output register before its slot is released.
// Reset clears the length, all marks and the handshake state; the stored
// edges need no reset since only entries inside the length are ever used.
`default_nettype none

module simple_path_edge_builder_top #(
	parameter int MAX_EDGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  spb_pkg::spb_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spb_pkg::spb_rsp_t rsp
);
	import spb_pkg::*;

	localparam int LW = $clog2(MAX_EDGES + 1);

	function automatic int f_levels(input int n);
		int c;
		int l;
		c = n;
		l = 0;
		while (c > 1) begin
			c = (c + FANIN - 1) / FANIN;
			l++;
		end
		return (l < 1) ? 1 : l;
	endfunction

	localparam int LEVELS = f_levels(MAX_EDGES);
	localparam int WCW    = $clog2(LEVELS) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_WAIT,
		S_DEC,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [WCW-1:0]      wcnt_q;

	// current item
	req_code_t           req_q;
	logic [EDGE_W-1:0]   key_q;
	logic                strict_q;

	// walk state
	logic [LW-1:0]       len_q;
	logic                simple_q;
	logic                prime_q;
	logic                cycle_q;
	logic [EDGE_W-1:0]   first_q;

	// pending result and output register
	spb_rsp_t            res_q;
	spb_rsp_t            rsp_q;
	logic                rsp_valid_q;

	// cell chain
	spb_cell_ctl_t       cell_ctl;
	logic [EDGE_W-1:0]   cell_v [MAX_EDGES];
	logic [MAX_EDGES-1:0] cell_gt;
	logic [MAX_EDGES-1:0] cell_eq;
	logic                hit;

	// decide outputs
	logic                ins_c;
	status_code_t        st_c;
	logic                fnd_c;
	logic                simple_c;
	logic                prime_c;
	logic                cycle_c;
	logic [LW-1:0]       len_c;
	logic [EDGE_W-1:0]   first_c;

	// cell chain control
	assign cell_ctl.cmp = (state_q == S_CMP);
	assign cell_ctl.ins = (state_q == S_DEC) && ins_c;

	for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
		logic [EDGE_W-1:0] lv;
		logic              lg;

		if (i == 0) begin : g_head
			assign lv = key_q;
			assign lg = 1'b0;
		end else begin : g_body
			assign lv = cell_v[i-1];
			assign lg = cell_gt[i-1];
		end

		spb_cell #(
			.IDX (i),
			.LW  (LW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.key     (key_q),
			.len     (len_q),
			.left_v  (lv),
			.left_gt (lg),
			.v_q     (cell_v[i]),
			.gt_q    (cell_gt[i]),
			.eq_q    (cell_eq[i])
		);
	end

	// membership: any occupied cell equal to the key
	spb_or_tree #(
		.N (MAX_EDGES)
	) u_tree (
		.clk  (clk),
		.leaf (cell_eq),
		.root (hit)
	);

	// request decision
	always_comb begin
		ins_c    = 1'b0;
		st_c     = ST_OK;
		fnd_c    = 1'b0;
		simple_c = simple_q;
		prime_c  = prime_q;
		cycle_c  = cycle_q;
		len_c    = len_q;
		first_c  = first_q;
		unique case (req_q)
			REQ_EXTEND: begin
				if (len_q == '0) begin
					ins_c    = 1'b1;
					simple_c = 1'b1;
					first_c  = key_q;
				end else if (prime_q && strict_q) begin
					st_c = ST_REJECT;
				end else if (len_q >= LW'(MAX_EDGES)) begin
					st_c = ST_FULL;
				end else begin
					if (prime_q) begin
						simple_c = 1'b0;
					end
					if (simple_c && hit) begin
						if (first_q == key_q) begin
							prime_c = 1'b1;
							cycle_c = 1'b1;
							ins_c   = 1'b1;
						end else if (!strict_q) begin
							simple_c = 1'b0;
							ins_c    = 1'b1;
						end else begin
							st_c = ST_REJECT;
						end
					end else begin
						ins_c = 1'b1;
					end
				end
				if (ins_c) begin
					len_c = len_q + LW'(1);
				end
			end
			REQ_QUERY: begin
				fnd_c = hit;
			end
			REQ_CLEAR: begin
				simple_c = 1'b0;
				prime_c  = 1'b0;
				cycle_c  = 1'b0;
				len_c    = '0;
			end
			default: begin
			end
		endcase
	end

	// item payload, first edge, pending result and output register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			req_q    <= cmd.req_type;
			key_q    <= cmd.edge_id;
			strict_q <= cmd.strict;
		end
		if (state_q == S_DEC) begin
			first_q               <= first_c;
			res_q.status          <= st_c;
			res_q.found           <= fnd_c;
			res_q.is_simple       <= simple_c;
			res_q.is_prime        <= prime_c;
			res_q.closed_cycle    <= cycle_c;
			res_q.walk_length     <= LEN_OUT_W'(len_c);
		end
		if (state_q == S_OUT && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

	// sequencer, walk length and marks, and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wcnt_q      <= '0;
			len_q       <= '0;
			simple_q    <= 1'b0;
			prime_q     <= 1'b0;
			cycle_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output valid: set on a result load, cleared when the item is taken
			if (state_q == S_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					wcnt_q  <= '0;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					wcnt_q <= wcnt_q + WCW'(1);
					if (wcnt_q == WCW'(LEVELS - 1)) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					len_q    <= len_c;
					simple_q <= simple_c;
					prime_q  <= prime_c;
					cycle_q  <= cycle_c;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
